/* rtl/positional_list_engine_top_assert.svh */
// Assertion macros shared by the list engine modules.
// Needs clk and rst_n in scope at every use; empty under SYNTHESIS.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset
`define PLE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLE_ASSERT(lbl, cond, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/ple_pkg.sv */
// Shared types and constants of the positional list engine.
// No dependencies; used by ple_ctrl, ple_dp and the top level.
package ple_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_O_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;   // take a new request
    logic start;   // load the walk pointer
    logic rd;      // read at the walk pointer and step it
    logic proc;    // handle the entry read in the previous cycle
    logic wr_val;  // write the inserted value at its slot
    logic finish;  // commit count and load the result register
  } ple_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_loc;
    logic ins_ok;
    logic del_ok;
    logic walk_empty;
    logic walk_last;
    logic hit;
  } ple_sts_t;

endpackage

/* rtl/ple_dp.sv */
// Datapath of the positional list engine: entry memory, walk pointer,
// count and result register. Depends on ple_pkg and the assertion header.
`include "positional_list_engine_top_assert.svh"

module ple_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ple_pkg::ple_cmd_t             cmd,
  output ple_pkg::ple_sts_t             sts,
  input  logic [ple_pkg::OP_W-1:0]      op,
  input  logic [ple_pkg::POS_W-1:0]     position,
  input  logic signed [ple_pkg::VAL_W-1:0] value_in,
  output logic                          ok,
  output logic signed [ple_pkg::VAL_W-1:0] value_out,
  output logic [ple_pkg::POS_W-1:0]     found_position,
  output logic [ple_pkg::CNT_O_W-1:0]   entry_count
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  logic signed [ple_pkg::VAL_W-1:0] mem_r [CAPACITY];
  logic signed [ple_pkg::VAL_W-1:0] rdata_r;

  logic [ple_pkg::OP_W-1:0]         op_r;
  logic [ple_pkg::POS_W-1:0]        pos_r;
  logic signed [ple_pkg::VAL_W-1:0] val_r;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [AW-1:0]                    ptr_r, pend_addr_r;
  logic                             pend_r;
  logic signed [ple_pkg::VAL_W-1:0] removed_r;
  logic                             found_r;
  logic [ple_pkg::POS_W-1:0]        found_pos_r;

  logic [CMPW-1:0] pos_c, cnt_c;
  logic [AW-1:0]   pos_m1, end_addr, start_addr;
  logic            is_ins, is_del, is_loc, ins_ok, del_ok;
  logic            we, hit, take_removed;
  logic [AW-1:0]   waddr;
  logic signed [ple_pkg::VAL_W-1:0] wdata;

  assign pos_c  = CMPW'(pos_r);
  assign cnt_c  = CMPW'(count_r);
  assign pos_m1 = AW'(pos_c - CMPW'(1));
  assign is_ins = (op_r == ple_pkg::OP_INSERT);
  assign is_del = (op_r == ple_pkg::OP_DELETE);
  assign is_loc = (op_r == ple_pkg::OP_LOCATE);
  assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + CMPW'(1)) &&
                  (count_r != CW'(CAPACITY));
  assign del_ok = (pos_c != '0) && (pos_c <= cnt_c);

  // insert walks down from the top entry, delete and locate walk up
  assign start_addr = is_ins ? AW'(cnt_c - CMPW'(1)) : (is_del ? pos_m1 : '0);
  assign end_addr   = is_ins ? pos_m1 : AW'(cnt_c - CMPW'(1));

  assign hit          = cmd.proc && pend_r && is_loc && (rdata_r == val_r);
  assign take_removed = cmd.proc && pend_r && is_del && (pend_addr_r == pos_m1);

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_r;
    wdata = rdata_r;
    if (cmd.wr_val) begin
      we    = 1'b1;
      waddr = pos_m1;
      wdata = val_r;
    end else if (cmd.proc && pend_r && is_ins) begin
      we    = 1'b1;
      waddr = pend_addr_r + AW'(1);
    end else if (cmd.proc && pend_r && is_del && !take_removed) begin
      we    = 1'b1;
      waddr = pend_addr_r - AW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (is_ins && ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (is_del && del_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign sts.is_ins     = is_ins;
  assign sts.is_del     = is_del;
  assign sts.is_loc     = is_loc;
  assign sts.ins_ok     = ins_ok;
  assign sts.del_ok     = del_ok;
  assign sts.walk_empty = is_ins ? (pos_c == cnt_c + CMPW'(1)) : (count_r == '0);
  assign sts.walk_last  = (ptr_r == end_addr);
  assign sts.hit        = hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem_r[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.rd;
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r        <= op;
      pos_r       <= position;
      val_r       <= value_in;
      removed_r   <= '0;
      found_r     <= 1'b0;
      found_pos_r <= '0;
    end else begin
      if (take_removed) begin
        removed_r <= rdata_r;
      end
      if (hit && !found_r) begin
        found_r     <= 1'b1;
        found_pos_r <= ple_pkg::POS_W'(CW'(pend_addr_r) + CW'(1));
      end
    end
    if (cmd.start) begin
      ptr_r <= start_addr;
    end else if (cmd.rd) begin
      ptr_r <= is_ins ? ptr_r - AW'(1) : ptr_r + AW'(1);
    end
    if (cmd.rd) begin
      pend_addr_r <= ptr_r;
    end
    if (cmd.finish) begin
      ok             <= (is_ins && ins_ok) || (is_del && del_ok) || found_r;
      value_out      <= removed_r;
      found_position <= found_pos_r;
      entry_count    <= ple_pkg::CNT_O_W'(count_nxt);
    end
  end

  `PLE_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "count above capacity")
  `PLE_ASSERT(a_wr_val_legal, !cmd.wr_val || (is_ins && ins_ok), "value write without legal insert")
  `PLE_ASSERT(a_hit_locate, !hit || is_loc, "match outside a locate")

endmodule

/* rtl/ple_ctrl.sv */
// Controller of the positional list engine: sequences the memory walk
// and owns both handshakes. Depends on ple_pkg and the assertion header.
`include "positional_list_engine_top_assert.svh"

module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ple_pkg::ple_sts_t sts,
  output ple_pkg::ple_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.latch     = in_fire;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_ins && sts.ins_ok) begin
          if (sts.walk_empty) begin
            state_nxt = S_FINAL;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_WALK;
          end
        end else if ((sts.is_del && sts.del_ok) || (sts.is_loc && !sts.walk_empty)) begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        cmd.rd   = 1'b1;
        cmd.proc = 1'b1;
        if (sts.hit) begin
          state_nxt = S_DONE;
        end else if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.proc  = 1'b1;
        state_nxt = sts.is_ins ? S_FINAL : S_DONE;
      end
      S_FINAL: begin
        cmd.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PLE_ASSERT_NEXT(a_accept_check, in_fire, state_r == S_CHECK, "accept not followed by check")
  `PLE_ASSERT(a_finish_free, !cmd.finish || !out_valid_r || out_tready, "result overwritten")
  `PLE_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r && state_r == S_IDLE, "result not shown")

endmodule

/* rtl/positional_list_engine_top.sv */
// Top level of the positional list engine: ports and the controller and
// datapath instances. Depends on ple_pkg, ple_ctrl and ple_dp.

// An ordered list of up to CAPACITY signed 32-bit entries in one memory with
// a registered read port. One request is handled at a time; each gives one
// result. Insert, delete and locate walk through the memory, reading one
// entry and, for insert and delete, moving one entry per cycle; an insert at
// the end skips the walk, and an op that fails its range check, op 3 or a
// locate on an empty list goes straight to the result. A new request is
// taken once the previous result is in the output register, even while that
// result still waits to be taken.
module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [7:0], value_in [39:8]
  input  logic [1:0]  in_tuser,   // op [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value_out [31:0], found_position [39:32],
                                  // entry_count [47:40]
  output logic [0:0]  out_tuser   // ok [0]
);

  ple_pkg::ple_cmd_t cmd;
  ple_pkg::ple_sts_t sts;

  logic                                    ok;
  logic signed [ple_pkg::VAL_W-1:0]        value_out;
  logic [ple_pkg::POS_W-1:0]               found_position;
  logic [ple_pkg::CNT_O_W-1:0]             entry_count;

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .op             (in_tuser),
    .position       (in_tdata[7:0]),
    .value_in       (in_tdata[39:8]),
    .ok             (ok),
    .value_out      (value_out),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  assign out_tdata = {entry_count, found_position, value_out};
  assign out_tuser = ok;

endmodule

/* verif/positional_list_engine_top_tb.sv */
// Self-checking testbench for positional_list_engine_top: drives list requests
// and checks every result against an in-bench model of the list.
// Depends on ple_pkg and the RTL of the engine; needs nothing else.
module positional_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = 128;
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = LIST_DEPTH + 12;

  typedef struct packed {
    logic                        ok;
    logic [ple_pkg::VAL_W-1:0]   value_out;
    logic [ple_pkg::POS_W-1:0]   found_position;
    logic [ple_pkg::CNT_O_W-1:0] entry_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // position [7:0], value_in [39:8]
  logic [1:0]  in_tuser = '0;   // op [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // value_out [31:0], found_position [39:32],
                                // entry_count [47:40]
  logic [0:0]  out_tuser;       // ok [0]

  // model of the list contents
  logic [ple_pkg::VAL_W-1:0] shadow_list [LIST_DEPTH];
  int                        shadow_count = 0;
  list_result_t              pending_results [$];
  int                        error_count = 0;
  bit                        no_idle = 1'b0;

  positional_list_engine_top #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Apply one accepted request to the model and queue the result it gives
  function automatic void apply_list_op(logic [ple_pkg::OP_W-1:0] op,
                                        logic [ple_pkg::POS_W-1:0] pos,
                                        logic [ple_pkg::VAL_W-1:0] val);
    list_result_t res;
    int           p;
    int           k;
    res = '0;
    p   = int'(pos);
    case (op)
      ple_pkg::OP_INSERT: begin
        if (p >= 1 && p <= shadow_count + 1 && shadow_count < LIST_DEPTH) begin
          for (k = shadow_count; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = val;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (p >= 1 && p <= shadow_count) begin
          res.value_out = shadow_list[p-1];
          for (k = p; k < shadow_count; k++) shadow_list[k-1] = shadow_list[k];
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      ple_pkg::OP_LOCATE: begin
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_list[k] == val) begin
            res.found_position = ple_pkg::POS_W'(k + 1);
            res.ok = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = ple_pkg::CNT_O_W'(shadow_count);
    pending_results.push_back(res);
  endfunction

  task automatic send_request(logic [ple_pkg::OP_W-1:0] op, logic [ple_pkg::POS_W-1:0] pos,
                              logic [ple_pkg::VAL_W-1:0] val);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, pos};
    do @(posedge clk); while (!in_tready);
    apply_list_op(op, pos, val);
  endtask

  // Hold off new requests until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom;
    if (r < 80) return ple_pkg::VAL_W'($signed($urandom_range(0, 7)) - 4);
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  always @(negedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok             = out_tuser[0];
      got.value_out      = out_tdata[31:0];
      got.found_position = out_tdata[39:32];
      got.entry_count    = out_tdata[47:40];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result ok=%0b value=%0d pos=%0d count=%0d", $realtime,
                 got.ok, $signed(got.value_out), got.found_position, got.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: mismatch expected ok=%0b value=%0d pos=%0d count=%0d", $realtime,
                   want.ok, $signed(want.value_out), want.found_position, want.entry_count);
          $display("%0t:          actual   ok=%0b value=%0d pos=%0d count=%0d", $realtime,
                   got.ok, $signed(got.value_out), got.found_position, got.entry_count);
        end
      end
    end
  end

  task automatic test_edge_cases();
    // empty list, range checks, both value extremes, duplicates, unused op
    send_request(ple_pkg::OP_LOCATE, 8'd0, 32'h0000_0000);
    send_request(ple_pkg::OP_DELETE, 8'd1, 32'h0000_0000);
    send_request(ple_pkg::OP_INSERT, 8'd0, 32'h1234_5678);
    send_request(ple_pkg::OP_INSERT, 8'd2, 32'h1234_5678);
    send_request(ple_pkg::OP_INSERT, 8'd1, 32'h8000_0000);
    send_request(ple_pkg::OP_INSERT, 8'd2, 32'h7fff_ffff);
    send_request(ple_pkg::OP_INSERT, 8'd1, 32'hffff_ffff);
    send_request(ple_pkg::OP_INSERT, 8'd2, 32'd5);
    send_request(ple_pkg::OP_INSERT, 8'd4, 32'd5);
    send_request(ple_pkg::OP_INSERT, 8'd255, 32'h0000_0000);
    send_request(ple_pkg::OP_LOCATE, 8'd0, 32'd5);
    send_request(ple_pkg::OP_LOCATE, 8'd255, 32'h7fff_ffff);
    send_request(ple_pkg::OP_LOCATE, 8'd0, 32'hffff_ffff);
    send_request(ple_pkg::OP_LOCATE, 8'd0, 32'h5555_aaaa);
    send_request(ple_pkg::OP_DELETE, 8'd0, 32'h0000_0000);
    send_request(ple_pkg::OP_DELETE, 8'd6, 32'h0000_0000);
    send_request(ple_pkg::OP_DELETE, 8'd255, 32'hffff_ffff);
    send_request(ple_pkg::OP_DELETE, 8'd3, 32'h0000_0000);
    send_request(ple_pkg::OP_DELETE, 8'd4, 32'h0000_0000);
    send_request(ple_pkg::OP_DELETE, 8'd1, 32'h0000_0000);
    send_request(OP_UNUSED, 8'd1, 32'hffff_ffff);
    send_request(OP_UNUSED, 8'd255, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_full_list();
    no_idle = 1'b1;
    while (shadow_count < LIST_DEPTH)
      send_request(ple_pkg::OP_INSERT,
                   ple_pkg::POS_W'($urandom_range(1, shadow_count + 1)), pick_value());
    send_request(ple_pkg::OP_INSERT, 8'd1, 32'h0bad_f00d);
    send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(LIST_DEPTH + 1), 32'h0bad_f00d);
    send_request(ple_pkg::OP_LOCATE, 8'd0, shadow_list[LIST_DEPTH-1]);
    send_request(ple_pkg::OP_LOCATE, 8'd0, shadow_list[0]);
    send_request(ple_pkg::OP_DELETE, ple_pkg::POS_W'(LIST_DEPTH), 32'h0000_0000);
    send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(LIST_DEPTH), 32'h7fff_ffff);
    send_request(ple_pkg::OP_DELETE, 8'd1, 32'h0000_0000);
    no_idle = 1'b0;
    drain_results();
  endtask

  // Mostly well-formed requests with random content; grow_pct sets the insert share
  task automatic test_random_traffic(int n, int unsigned grow_pct);
    int unsigned               r;
    logic [ple_pkg::VAL_W-1:0] v;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_request(ple_pkg::OP_W'($urandom_range(3)), ple_pkg::POS_W'($urandom_range(255)),
                     $urandom);
      end else if (r < 8 + grow_pct) begin
        send_request(ple_pkg::OP_INSERT,
                     ple_pkg::POS_W'($urandom_range(1, shadow_count + 1)), pick_value());
      end else if (r < 8 + grow_pct + (92 - grow_pct) / 2) begin
        send_request(ple_pkg::OP_DELETE,
                     ple_pkg::POS_W'($urandom_range(1, shadow_count > 0 ? shadow_count : 1)),
                     $urandom);
      end else begin
        if (shadow_count > 0 && $urandom_range(1))
          v = shadow_list[$urandom_range(0, shadow_count - 1)];
        else
          v = pick_value();
        send_request(ple_pkg::OP_LOCATE, ple_pkg::POS_W'($urandom_range(255)), v);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_edge_cases();
    test_full_list();
    test_random_traffic(150, 20);
    drain_results();
    test_random_traffic(150, 55);
    test_random_traffic(100, 38);

    drain_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
